>>> src/tmrq_pkg.sv
package tmrq_pkg;

	typedef enum logic [2:0] {
		CMD_ADD        = 3'd0,
		CMD_ADD_NEWER  = 3'd1,
		CMD_MARK       = 3'd2,
		CMD_RELEASE    = 3'd3,
		CMD_CLEAR      = 3'd4,
		CMD_COUNT      = 3'd5,
		CMD_READ       = 3'd6,
		CMD_NOP        = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] stamp;
		logic [31:0] index_value;
		logic [31:0] payload;
	} in_beat_t;

	typedef struct packed {
		logic        accepted;
		logic        full_drop;
		logic        entry_valid;
		logic [31:0] entry_stamp;
		logic [31:0] entry_number;
		logic [31:0] entry_payload;
		logic [5:0]  tally;
		logic [31:0] last_added_stamp;
		logic [31:0] last_processed_stamp;
		logic        last;
	} out_beat_t;

	typedef struct packed {
		logic [31:0] stamp;
		logic [31:0] number;
		logic [31:0] payload;
	} entry_t;

	// row control, same for every cell
	typedef enum logic [1:0] {
		ROW_HOLD  = 2'd0,
		ROW_SHIFT = 2'd1,
		ROW_ROT   = 2'd2
	} row_op_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_COUNT = 3'd1,
		ST_REL   = 3'd2,
		ST_READ  = 3'd3,
		ST_OUT   = 3'd4
	} state_t;

endpackage

>>> src/tmrq_cell.sv
module tmrq_cell
	import tmrq_pkg::*;
(
	input  logic    clk,
	input  row_op_t op,
	input  entry_t  from_next,
	input  logic    load,
	input  entry_t  load_data,
	output entry_t  data
);
	entry_t data_q;

	// shift and rotate both take from the cell behind; the last cell is fed from the front
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else begin
			unique case (op)
				ROW_SHIFT, ROW_ROT: data_q <= from_next;
				default:            data_q <= data_q;
			endcase
		end
	end

	assign data = data_q;
endmodule

>>> src/timestamped_move_retransmit_queue_unit.sv
// channel | direction | payload type | handshake
// in      | input     | in_beat_t    | in_valid / in_stall
// out     | output    | out_beat_t   | out_valid / out_stall
//
// the queue is a row of DEPTH cells with the front entry always in cell 0.
// add, mark, clear, nop: result beat in the cycle after acceptance.
// count_after rotates the whole row once; read_at rotates once too; release
// frees one front entry per cycle while the output is not stalled,
// one beat per freed entry (an empty release is one beat).
// reset clears occupancy and both timestamps; cell contents are undefined.
// a stalled output beat holds; no new item is taken until the last beat leaves.
module timestamped_move_retransmit_queue_unit
	import tmrq_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MAXR = 32;

	state_t   state_q, state_d;
	in_beat_t item_q;
	logic [CW-1:0] occ_q, occ_d;
	logic [CW-1:0] step_q, step_d;
	logic [5:0]    cnt_q, cnt_d;
	logic [31:0]   newest_q, newest_d, proc_q, proc_d;
	out_beat_t     obuf_q, obuf_d;
	logic          ovalid_q, ovalid_d;
	logic          rel_last_q, rel_last_d;

	row_op_t  op;
	logic     push;
	entry_t   cells [DEPTH];
	entry_t   new_entry;
	logic     full;
	logic     read_hit;
	logic     rel_end;

	assign new_entry = '{stamp: in_data.stamp, number: in_data.index_value,
		payload: in_data.payload};
	assign full = (occ_q >= CW'(DEPTH));

	// wanted read position is in cell 0 this cycle
	assign read_hit = (item_q.index_value < 32'(occ_q)) &&
		(32'(step_q) == item_q.index_value);

	// beat freed this cycle closes the release: queue empties, beat limit,
	// or the next front entry is newer than the ack
	assign rel_end = (occ_q == CW'(1)) || (32'(step_q) == 32'(MAXR - 1)) ||
		(cells[1].stamp > item_q.stamp);

	// cell row, cell i feeds cell i-1 on a shift
	for (genvar i = 0; i < DEPTH; i++) begin : g_row
		entry_t nxt;
		if (i == DEPTH - 1) begin : g_end
			assign nxt = cells[0];
		end else begin : g_mid
			assign nxt = cells[i+1];
		end
		tmrq_cell u_cell (
			.clk       (clk),
			.op        (op),
			.from_next (nxt),
			.load      (push && (occ_d == CW'(i + 1))),
			.load_data (new_entry),
			.data      (cells[i])
		);
	end

	// a beat with the status fields filled in
	function automatic out_beat_t status(input logic [5:0] t, input logic [31:0] na,
		input logic [31:0] pr);
		out_beat_t b;
		b = '0;
		b.tally = t;
		b.last_added_stamp = na;
		b.last_processed_stamp = pr;
		b.last = 1'b1;
		return b;
	endfunction

	assign in_stall = (state_q != ST_IDLE) || ovalid_q;
	assign out_valid = ovalid_q;
	assign out_data = obuf_q;

	always_comb begin
		state_d = state_q;
		occ_d = occ_q;
		step_d = step_q;
		cnt_d = cnt_q;
		newest_d = newest_q;
		proc_d = proc_q;
		obuf_d = obuf_q;
		ovalid_d = ovalid_q;
		rel_last_d = rel_last_q;
		op = ROW_HOLD;
		push = 1'b0;
		if (ovalid_q && !out_stall) begin
			ovalid_d = 1'b0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !in_stall) begin
					unique case (cmd_t'(in_data.cmd))
						CMD_ADD, CMD_ADD_NEWER: begin
							obuf_d = status(6'(occ_q), newest_q, proc_q);
							if (in_data.cmd == CMD_ADD || in_data.stamp > newest_q) begin
								if (full) begin
									obuf_d.full_drop = 1'b1;
								end else begin
									push = 1'b1;
									occ_d = occ_q + 1'b1;
									newest_d = in_data.stamp;
									obuf_d.accepted = 1'b1;
									obuf_d.tally = 6'(occ_d);
									obuf_d.last_added_stamp = in_data.stamp;
								end
							end
							ovalid_d = 1'b1;
						end
						CMD_MARK: begin
							proc_d = in_data.stamp;
							obuf_d = status(6'(occ_q), newest_q, in_data.stamp);
							ovalid_d = 1'b1;
						end
						CMD_CLEAR: begin
							occ_d = '0;
							obuf_d = status(6'd0, newest_q, proc_q);
							ovalid_d = 1'b1;
						end
						CMD_RELEASE: begin
							step_d = '0;
							rel_last_d = 1'b0;
							state_d = ST_REL;
						end
						CMD_COUNT: begin
							step_d = '0;
							cnt_d = '0;
							state_d = ST_COUNT;
						end
						CMD_READ: begin
							step_d = '0;
							state_d = ST_READ;
						end
						default: begin
							obuf_d = status(6'(occ_q), newest_q, proc_q);
							ovalid_d = 1'b1;
						end
					endcase
				end
			end
			ST_COUNT: begin
				// one full rotation, checking cell 0 each cycle
				op = ROW_ROT;
				if (step_q < occ_q && cells[0].stamp > item_q.stamp) begin
					cnt_d = cnt_q + 1'b1;
				end
				step_d = step_q + 1'b1;
				if (step_q == CW'(DEPTH - 1)) begin
					state_d = ST_OUT;
				end
			end
			ST_READ: begin
				// rotate fully; catch the wanted entry as it passes cell 0
				op = ROW_ROT;
				if (read_hit) begin
					obuf_d = status(6'(occ_q), newest_q, proc_q);
					obuf_d.entry_valid = 1'b1;
					obuf_d.entry_stamp = cells[0].stamp;
					obuf_d.entry_number = cells[0].number;
					obuf_d.entry_payload = cells[0].payload;
					rel_last_d = 1'b1;
				end
				step_d = step_q + 1'b1;
				if (step_q == CW'(DEPTH - 1)) begin
					if (!rel_last_q && !read_hit) begin
						obuf_d = status(6'(occ_q), newest_q, proc_q);
					end
					rel_last_d = 1'b0;
					ovalid_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_REL: begin
				if (!ovalid_q || !out_stall) begin
					if (occ_q != '0 && 32'(step_q) < 32'(MAXR) &&
						cells[0].stamp <= item_q.stamp) begin
						op = ROW_SHIFT;
						occ_d = occ_q - 1'b1;
						step_d = step_q + 1'b1;
						obuf_d = status(6'(occ_d), newest_q, proc_q);
						obuf_d.last = rel_end;
						obuf_d.entry_valid = 1'b1;
						obuf_d.entry_stamp = cells[0].stamp;
						obuf_d.entry_number = cells[0].number;
						obuf_d.entry_payload = cells[0].payload;
						ovalid_d = 1'b1;
						if (rel_end) begin
							state_d = ST_IDLE;
						end
					end else begin
						// nothing to free: a single status beat
						obuf_d = status(6'(occ_q), newest_q, proc_q);
						ovalid_d = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_OUT: begin
				obuf_d = status(cnt_q, newest_q, proc_q);
				ovalid_d = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q <= '0;
			step_q <= '0;
			cnt_q <= '0;
			newest_q <= '0;
			proc_q <= '0;
			ovalid_q <= 1'b0;
			rel_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q <= occ_d;
			step_q <= step_d;
			cnt_q <= cnt_d;
			newest_q <= newest_d;
			proc_q <= proc_d;
			ovalid_q <= ovalid_d;
			rel_last_q <= rel_last_d;
		end
	end

	always_ff @(posedge clk) begin
		obuf_q <= obuf_d;
		if (in_valid && !in_stall) begin
			item_q <= in_data;
		end
	end
endmodule

>>> src/tmrq_checker.sv
module tmrq_assertions
	import tmrq_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_beat_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output beat changed");
	a_tally: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.tally <= 6'd32)
		else $error("tally out of range");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.accepted && out_data.full_drop))
		else $error("accepted and dropped together");
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.entry_valid)
		else $error("non-final beat without entry");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall || !in_valid || in_stall)
		else $error("input taken while an output beat waits");
endmodule

bind timestamped_move_retransmit_queue_unit tmrq_assertions u_tmrq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> tb/tmrq_checker.sv
`timescale 1ns / 100ps

module tmrq_checker
	import tmrq_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_beat_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_beat_t out_data,
	output int        fail_count,
	output int        pending
);

	localparam int MAX_BEATS = 32;

	logic [31:0] q_stamp [DEPTH];
	logic [31:0] q_number [DEPTH];
	logic [31:0] q_payload [DEPTH];
	int unsigned head;
	int unsigned fill;
	logic [31:0] newest;
	logic [31:0] processed;
	out_beat_t expected_beats [$];

	function automatic out_beat_t status_beat(int unsigned tally);
		out_beat_t b;
		b = '0;
		b.tally = tally[5:0];
		b.last_added_stamp = newest;
		b.last_processed_stamp = processed;
		b.last = 1'b1;
		return b;
	endfunction

	function automatic out_beat_t entry_beat(int unsigned slot, int unsigned tally);
		out_beat_t b;
		b = status_beat(tally);
		b.entry_valid = 1'b1;
		b.entry_stamp = q_stamp[slot];
		b.entry_number = q_number[slot];
		b.entry_payload = q_payload[slot];
		return b;
	endfunction

	task automatic predict_command(input in_beat_t item);
		out_beat_t b;
		int unsigned slot;
		int unsigned cnt;
		int n;
		case (cmd_t'(item.cmd))
			CMD_ADD, CMD_ADD_NEWER: begin
				logic acc;
				logic drop;
				acc = 1'b0;
				drop = 1'b0;
				if (item.cmd == CMD_ADD || item.stamp > newest) begin
					if (fill >= DEPTH) begin
						drop = 1'b1;
					end else begin
						slot = (head + fill) % DEPTH;
						q_stamp[slot] = item.stamp;
						q_number[slot] = item.index_value;
						q_payload[slot] = item.payload;
						fill++;
						newest = item.stamp;
						acc = 1'b1;
					end
				end
				b = status_beat(fill);
				b.accepted = acc;
				b.full_drop = drop;
				expected_beats.push_back(b);
			end
			CMD_MARK: begin
				processed = item.stamp;
				expected_beats.push_back(status_beat(fill));
			end
			CMD_RELEASE: begin
				n = 0;
				while (n < MAX_BEATS && fill > 0 && q_stamp[head] <= item.stamp) begin
					slot = head;
					head = (head + 1) % DEPTH;
					fill--;
					b = entry_beat(slot, fill);
					b.last = 1'b0;
					expected_beats.push_back(b);
					n++;
				end
				if (n == 0) expected_beats.push_back(status_beat(fill));
				else expected_beats[$].last = 1'b1;
			end
			CMD_CLEAR: begin
				fill = 0;
				head = 0;
				expected_beats.push_back(status_beat(fill));
			end
			CMD_COUNT: begin
				cnt = 0;
				for (int i = 0; i < fill; i++)
					if (q_stamp[(head + i) % DEPTH] > item.stamp) cnt++;
				expected_beats.push_back(status_beat(cnt));
			end
			CMD_READ: begin
				if (item.index_value < fill)
					expected_beats.push_back(entry_beat((head + item.index_value) % DEPTH, fill));
				else
					expected_beats.push_back(status_beat(fill));
			end
			default: expected_beats.push_back(status_beat(fill));
		endcase
	endtask

	task automatic compare_beat(input out_beat_t got);
		out_beat_t exp;
		if (expected_beats.size() == 0) begin
			$error("unexpected out beat %h", got);
			fail_count++;
			return;
		end
		exp = expected_beats[0];
		expected_beats.delete(0);
		if (got.accepted !== exp.accepted) begin
			$error("accepted exp %0d got %0d", exp.accepted, got.accepted); fail_count++;
		end
		if (got.full_drop !== exp.full_drop) begin
			$error("full_drop exp %0d got %0d", exp.full_drop, got.full_drop); fail_count++;
		end
		if (got.entry_valid !== exp.entry_valid) begin
			$error("entry_valid exp %0d got %0d", exp.entry_valid, got.entry_valid);
			fail_count++;
		end
		if (got.entry_stamp !== exp.entry_stamp) begin
			$error("entry_stamp exp %h got %h", exp.entry_stamp, got.entry_stamp);
			fail_count++;
		end
		if (got.entry_number !== exp.entry_number) begin
			$error("entry_number exp %h got %h", exp.entry_number, got.entry_number);
			fail_count++;
		end
		if (got.entry_payload !== exp.entry_payload) begin
			$error("entry_payload exp %h got %h", exp.entry_payload, got.entry_payload);
			fail_count++;
		end
		if (got.tally !== exp.tally) begin
			$error("tally exp %0d got %0d", exp.tally, got.tally); fail_count++;
		end
		if (got.last_added_stamp !== exp.last_added_stamp) begin
			$error("last_added_stamp exp %h got %h", exp.last_added_stamp,
				got.last_added_stamp);
			fail_count++;
		end
		if (got.last_processed_stamp !== exp.last_processed_stamp) begin
			$error("last_processed_stamp exp %h got %h", exp.last_processed_stamp,
				got.last_processed_stamp);
			fail_count++;
		end
		if (got.last !== exp.last) begin
			$error("last exp %0d got %0d", exp.last, got.last); fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			fill = 0;
			newest = '0;
			processed = '0;
			fail_count = 0;
			expected_beats.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) compare_beat(out_data);
			if (in_valid && !in_stall) predict_command(in_data);
			pending = expected_beats.size();
		end
	end

	final begin
		if (expected_beats.size() != 0)
			$error("%0d expected out beats never arrived", expected_beats.size());
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tmrq_pkg::*;

	localparam int DEPTH = 32;
	localparam int IDLE_LIMIT = 5000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;
	int        fail_count;
	int        pending;

	// receiver hold-off request from the stimulus process
	logic      hold_off;
	int        quiet_cycles;
	// running base for generated stamps
	logic [31:0] stamp_base;

	timestamped_move_retransmit_queue_unit #(.DEPTH(DEPTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	tmrq_checker #(.DEPTH(DEPTH)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one beat on the input channel, gap drawn first, held until accepted
	task automatic send_beat(input cmd_t cmd, input logic [31:0] stamp,
		input logic [31:0] idx, input logic [31:0] payload);
		int gap;
		gap = $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{cmd: cmd, stamp: stamp, index_value: idx, payload: payload};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// pause the sender until the block has delivered everything
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DEPTH + 8) @(negedge clk);
	endtask

	task automatic random_beat;
		int pick;
		cmd_t cmd;
		logic [31:0] stamp;
		logic [31:0] idx;
		pick = $urandom_range(0, 99);
		if (pick < 40) cmd = ($urandom_range(0, 1) != 0) ? CMD_ADD : CMD_ADD_NEWER;
		else if (pick < 50) cmd = CMD_MARK;
		else if (pick < 65) cmd = CMD_RELEASE;
		else if (pick < 68) cmd = CMD_CLEAR;
		else if (pick < 80) cmd = CMD_COUNT;
		else if (pick < 97) cmd = CMD_READ;
		else cmd = CMD_NOP;
		// mostly rising stamps near a running base, sometimes fully random
		if ($urandom_range(0, 9) == 0) stamp = $urandom;
		else stamp = stamp_base + $urandom_range(0, 40);
		if (cmd == CMD_ADD || cmd == CMD_ADD_NEWER) begin
			stamp_base = stamp_base + $urandom_range(0, 8);
			idx = $urandom;
		end else if (cmd == CMD_READ) begin
			idx = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, DEPTH + 1);
		end else begin
			idx = $urandom;
		end
		send_beat(cmd, stamp, idx, $urandom);
	endtask

	// receiver: random stall per beat, plus a long hold-off on request
	initial begin
		int wait_cycles;
		out_stall = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
			end else begin
				wait_cycles = $urandom_range(0, 3);
				if (wait_cycles != 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles - 1) @(negedge clk);
					@(negedge clk);
				end
				out_stall <= 1'b0;
				do @(posedge clk); while (!out_valid && !hold_off);
			end
		end
	end

	// watchdog on cycles with no accepted beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else if (!hold_off)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		hold_off = 1'b0;
		stamp_base = 32'd100;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty queue cases, extremes, every command
		send_beat(CMD_RELEASE, 32'hFFFF_FFFF, '0, '0);
		send_beat(CMD_READ, '0, '0, '0);
		send_beat(CMD_COUNT, '0, '0, '0);
		send_beat(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(CMD_ADD_NEWER, 32'hFFFF_FFFF, 32'h1, 32'h2);
		send_beat(CMD_ADD, '0, '0, '0);
		send_beat(CMD_ADD_NEWER, 32'h5, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		send_beat(CMD_MARK, 32'hFFFF_FFFF, '0, '0);
		send_beat(CMD_COUNT, 32'h4, '0, '0);
		send_beat(CMD_READ, '0, 32'd1, '0);
		send_beat(CMD_READ, '0, 32'd2, '0);
		send_beat(CMD_READ, '0, 32'hFFFF_FFFF, '0);
		send_beat(CMD_NOP, 32'h1234, 32'h5678, 32'h9ABC);
		send_beat(CMD_RELEASE, 32'h0, '0, '0);
		send_beat(CMD_CLEAR, '0, '0, '0);
		send_beat(CMD_MARK, '0, '0, '0);
		drain();

		// fill to overflow, then a full release of all entries
		for (int i = 0; i < DEPTH + 2; i++)
			send_beat(CMD_ADD, 32'd10 + i, i, $urandom);
		send_beat(CMD_COUNT, 32'd20, '0, '0);
		send_beat(CMD_READ, '0, DEPTH - 1, '0);
		send_beat(CMD_RELEASE, 32'hFFFF_FFFF, '0, '0);
		drain();

		// long receiver hold-off while the sender keeps pushing
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			begin
				for (int i = 0; i < 6; i++) random_beat();
			end
		join
		drain();

		for (int i = 0; i < 60; i++) begin
			random_beat();
			if (i % 20 == 19) drain();
		end
		drain();

		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
